>>> hdl/rrp_pkg.sv
// Shared types, result codes and parameter defaults for the RESP request parser.
`default_nettype none

package rrp_pkg;

   // Default widths of the argument count and of an argument length.
   localparam int COUNT_BITS_DEFAULT = 32;
   localparam int LEN_BITS_DEFAULT   = 32;

   // Result kinds.
   localparam logic [2:0] KIND_FRAME  = 3'd0;
   localparam logic [2:0] KIND_BYTE   = 3'd1;
   localparam logic [2:0] KIND_END    = 3'd2;
   localparam logic [2:0] KIND_FAIL   = 3'd3;
   localparam logic [2:0] KIND_IGNORE = 3'd4;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] payload;
      logic       first_arg;
      logic       command_end;
   } rrp_result_type;

endpackage

`default_nettype wire

>>> hdl/rrp_parse.sv
// Parser state machine: consumes one request byte per step and forms its result.
`default_nettype none

module rrp_parse #(
   parameter int COUNT_BITS = rrp_pkg::COUNT_BITS_DEFAULT,
   parameter int LEN_BITS   = rrp_pkg::LEN_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic [7:0]              byte_in,
   output rrp_pkg::rrp_result_type      result
);

   import rrp_pkg::*;

   localparam int NUM_BITS = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;

   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   typedef enum logic [2:0] {
      PH_STAR,
      PH_COUNT,
      PH_DOLLAR,
      PH_LEN,
      PH_DATA,
      PH_CR,
      PH_LF
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [NUM_BITS-1:0]     acc_ff, acc_in;
   logic                    bad_ff, bad_in;
   logic                    started_ff, started_in;
   logic                    cr_ff, cr_in;
   logic [COUNT_BITS-1:0]   expected_ff, expected_in;
   logic [COUNT_BITS-1:0]   done_ff, done_in;
   logic [LEN_BITS-1:0]     left_ff, left_in;
   logic                    failed_ff, failed_in;

   logic [NUM_BITS+3:0]     acc_ext;
   logic [NUM_BITS+3:0]     acc_next;
   logic [3:0]              digit;
   logic                    is_digit;
   logic                    is_count;
   logic                    overflow;
   logic                    number_ok;
   logic [COUNT_BITS:0]     done_inc;
   rrp_result_type          res;

   // acc * 10 + digit, wide enough that an overflow past the field width shows up.
   assign digit    = byte_in[3:0];
   assign is_digit = (byte_in >= CHAR_ZERO) && (byte_in <= CHAR_NINE);
   assign is_count = (phase_ff == PH_COUNT);
   assign acc_ext  = {4'b0000, acc_ff};
   assign acc_next = (acc_ext << 3) + (acc_ext << 1) + {{NUM_BITS{1'b0}}, digit};
   assign overflow = is_count ? ((acc_next >> COUNT_BITS) != '0)
                              : ((acc_next >> LEN_BITS) != '0);
   assign number_ok = started_ff && !bad_ff && (!is_count || (acc_ff != '0));
   assign done_inc  = {1'b0, done_ff} + {{COUNT_BITS{1'b0}}, 1'b1};

   always_comb begin
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      bad_in      = bad_ff;
      started_in  = started_ff;
      cr_in       = cr_ff;
      expected_in = expected_ff;
      done_in     = done_ff;
      left_in     = left_ff;
      failed_in   = failed_ff;
      res         = '{kind: KIND_FRAME, payload: 8'h00, first_arg: 1'b0, command_end: 1'b0};

      if (failed_ff) begin
         res.kind = KIND_IGNORE;
      end else begin
         case (phase_ff)
            PH_STAR, PH_DOLLAR: begin
               if (byte_in == ((phase_ff == PH_STAR) ? CHAR_STAR : CHAR_DOLLAR)) begin
                  acc_in     = '0;
                  bad_in     = 1'b0;
                  started_in = 1'b0;
                  cr_in      = 1'b0;
                  phase_in   = (phase_ff == PH_STAR) ? PH_COUNT : PH_LEN;
               end else begin
                  res.kind = KIND_FAIL;
               end
            end
            PH_COUNT, PH_LEN: begin
               if (cr_ff) begin
                  if (byte_in != CHAR_LF || !number_ok) begin
                     res.kind = KIND_FAIL;
                  end else if (is_count) begin
                     expected_in = acc_ff[COUNT_BITS-1:0];
                     done_in     = '0;
                     phase_in    = PH_DOLLAR;
                  end else begin
                     left_in  = acc_ff[LEN_BITS-1:0];
                     phase_in = (acc_ff == '0) ? PH_CR : PH_DATA;
                  end
                  if (byte_in == CHAR_LF) begin
                     acc_in     = '0;
                     bad_in     = 1'b0;
                     started_in = 1'b0;
                     cr_in      = 1'b0;
                  end
               end else if (byte_in == CHAR_CR) begin
                  cr_in = 1'b1;
               end else if (is_digit) begin
                  started_in = 1'b1;
                  if (!bad_ff) begin
                     if (overflow) begin
                        bad_in = 1'b1;
                     end else begin
                        acc_in = acc_next[NUM_BITS-1:0];
                     end
                  end
               end else begin
                  started_in = 1'b1;
                  bad_in     = 1'b1;
               end
            end
            PH_DATA: begin
               res.kind      = KIND_BYTE;
               res.first_arg = (done_ff == '0);
               res.payload   = byte_in;
               if ((done_ff == '0) && byte_in >= CHAR_LOW_A && byte_in <= CHAR_LOW_Z) begin
                  res.payload = byte_in - CASE_OFFSET;
               end
               left_in = left_ff - {{(LEN_BITS-1){1'b0}}, 1'b1};
               if (left_ff == {{(LEN_BITS-1){1'b0}}, 1'b1}) begin
                  phase_in = PH_CR;
               end
            end
            PH_CR: begin
               if (byte_in == CHAR_CR) begin
                  phase_in = PH_LF;
               end else begin
                  res.kind = KIND_FAIL;
               end
            end
            PH_LF: begin
               if (byte_in == CHAR_LF) begin
                  res.kind      = KIND_END;
                  res.first_arg = (done_ff == '0);
                  if (done_inc >= {1'b0, expected_ff}) begin
                     res.command_end = 1'b1;
                     done_in         = '0;
                     phase_in        = PH_STAR;
                  end else begin
                     done_in  = done_inc[COUNT_BITS-1:0];
                     phase_in = PH_DOLLAR;
                  end
               end else begin
                  res.kind = KIND_FAIL;
               end
            end
            default: begin
               res.kind = KIND_FAIL;
            end
         endcase
         if (res.kind == KIND_FAIL) begin
            failed_in = 1'b1;
         end
      end
   end

   assign result = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_STAR;
         acc_ff      <= '0;
         bad_ff      <= 1'b0;
         started_ff  <= 1'b0;
         cr_ff       <= 1'b0;
         expected_ff <= '0;
         done_ff     <= '0;
         left_ff     <= '0;
         failed_ff   <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         acc_ff      <= acc_in;
         bad_ff      <= bad_in;
         started_ff  <= started_in;
         cr_ff       <= cr_in;
         expected_ff <= expected_in;
         done_ff     <= done_in;
         left_ff     <= left_in;
         failed_ff   <= failed_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/resp_request_parser.sv
// Top level of the RESP multi-bulk request parser with its result register and skid stage.
//
//   Channel   Direction   Ports                                  Carries
//   req_      in          req_valid req_stall req_byte_req       one request byte per item
//   rsp_      out         rsp_valid rsp_stall rsp_kind           one result item per byte
//                         rsp_payload rsp_first_arg
//                         rsp_command_end
//
// Every accepted byte yields exactly one result item. It shows on the rsp_ ports in the cycle
// after the byte is accepted when no earlier result is still waiting, and later otherwise.
// A new byte may be accepted in every cycle while req_stall is low; the rate is set by the
// single pass through the parser's next-state logic, which updates the phase and counter
// registers at the accepting edge. The result register plus one skid entry let the parser
// keep taking bytes while a result waits; req_stall rises only when both hold items.
// Synchronous reset puts the parser at the start of a command and empties both stages.
`default_nettype none

module resp_request_parser #(
   parameter int COUNT_BITS = rrp_pkg::COUNT_BITS_DEFAULT,
   parameter int LEN_BITS   = rrp_pkg::LEN_BITS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_byte_req,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_kind,
   output logic [7:0]      rsp_payload,
   output logic            rsp_first_arg,
   output logic            rsp_command_end
);

   import rrp_pkg::*;

   logic           accept;
   logic           take;
   rrp_result_type result;

   // Output side: a result register and one skid entry behind it.
   logic           main_valid_ff, main_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   rrp_result_type main_ff, main_in;
   rrp_result_type skid_ff, skid_in;

   // The skid entry is the only reason to hold off the sender.
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign take      = main_valid_ff && !rsp_stall;

   rrp_parse #(
      .COUNT_BITS (COUNT_BITS),
      .LEN_BITS   (LEN_BITS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (accept),
      .byte_in (req_byte_req),
      .result  (result)
   );

   // Results leave in order: the skid entry always moves up before a new result lands.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            main_in = result;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!main_valid_ff) begin
            main_in       = result;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = main_valid_ff;
   assign rsp_kind        = main_ff.kind;
   assign rsp_payload     = main_ff.payload;
   assign rsp_first_arg   = main_ff.first_arg;
   assign rsp_command_end = main_ff.command_end;

`ifndef SYNTHESIS
   // The skid entry is never filled while the result register is empty.
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> main_valid_ff)
      else $error("skid entry holds an item ahead of an empty result register");

   // Once a failure is delivered, every later result reports an ignored byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && (rsp_kind == KIND_FAIL || rsp_kind == KIND_IGNORE))
      |=> (!rsp_valid || rsp_kind == KIND_IGNORE))
      else $error("parser produced a live result after a failure");

   // The payload byte and the command-end flag only travel with their own result kinds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_BYTE || rsp_payload == 8'h00)
                     && (!rsp_command_end || rsp_kind == KIND_END)))
      else $error("payload or command end set on the wrong result kind");

   // An accepted byte while nothing waits shows up as a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !main_valid_ff) |=> rsp_valid)
      else $error("accepted item did not reach the result register");
`endif

endmodule

`default_nettype wire
